>>> src/dimg_pkg.sv
package dimg_pkg;

    localparam int IMAGE_SIDE = 64;
    localparam int SPAN       = IMAGE_SIDE - 1;
    localparam int IDX_W      = $clog2(IMAGE_SIDE);
    localparam int ACC_W      = 72;

    localparam logic [1:0] REG_NEAR   = 2'd0;
    localparam logic [1:0] REG_FAR    = 2'd1;
    localparam logic [1:0] REG_CUTOFF = 2'd2;

    localparam logic [31:0] NEAR_RESET   = 32'd6554;
    localparam logic [31:0] FAR_RESET    = 32'd655360;
    localparam logic [15:0] CUTOFF_RESET = 16'd58982;

    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam logic [63:0] PI_SIXTH_Q30 = 64'd562209904;

    typedef logic signed [31:0] tan_tab_t [IMAGE_SIDE];

    // camera frame shared between the pose unit and the pixel pipeline
    typedef struct packed {
        logic [2:0][31:0] origin;
        logic [2:0][31:0] right;
        logic [2:0][31:0] up;
        logic [2:0][31:0] fwd;
    } frame_t;

    // restoring division, only evaluated while the table is built
    function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tan over -30..+30 degrees from Q30 sin and cos series
    function automatic tan_tab_t build_tan();
        tan_tab_t    tab;
        logic [63:0] km;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] q;
        logic        neg;
        longint      k;
        for (int i = 0; i < IMAGE_SIDE; i++) begin
            k   = 2 * longint'(i) - longint'(SPAN);
            neg = (k < 0);
            km  = neg ? 64'(-k) : 64'(k);
            a   = cdiv(PI_SIXTH_Q30 * km, 64'(SPAN));
            a2  = (a * a) >> 30;
            t   = Q30_ONE - cdiv(a2, 64'd72);
            t   = Q30_ONE - cdiv((a2 * t) >> 30, 64'd42);
            t   = Q30_ONE - cdiv((a2 * t) >> 30, 64'd20);
            t   = Q30_ONE - cdiv((a2 * t) >> 30, 64'd6);
            s   = (a * t) >> 30;
            c   = Q30_ONE - cdiv(a2, 64'd56);
            c   = Q30_ONE - cdiv((a2 * c) >> 30, 64'd30);
            c   = Q30_ONE - cdiv((a2 * c) >> 30, 64'd12);
            c   = Q30_ONE - ((a2 * c) >> 31);
            q   = cdiv((s << 16) + (c >> 1), c);
            tab[i] = neg ? -$signed(q[31:0]) : $signed(q[31:0]);
        end
        return tab;
    endfunction

    localparam tan_tab_t TAN_TAB = build_tan();

    // Q32.32 to Q16.16, nearest, half away from zero
    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m = (m + ACC_W'(32768)) >> 16;
        return v[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [31:0] r;
        if (v > ACC_W'(64'sd2147483647)) begin
            r = 32'h7fff_ffff;
        end else if (v < -ACC_W'(64'sd2147483648)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> src/depth_image_to_world_points.sv
// Pixel items: one pixel per cycle while m_tready is high and no pose item is in progress.
// Pose items: the look-at unit runs two normalizations, each a 32-step square root
// and three 48-step divisions (the divisions skipped for a zero vector), then waits
// for the pixel pipeline to drain; no input is taken meanwhile.
// Synchronous active-low reset restores the register defaults and clears the frame
// to zero; items in flight are dropped.
module depth_image_to_world_points
    import dimg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // depth[15:0], pixel_index[27:16], pos_x/y/z, dir_x/y/z, upvec_x/y/z
    // 32 bits each from bit 28 up, zero pad [319:316]
    input  logic [319:0] s_tdata,
    // kind[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // world_x[31:0], world_y[63:32], world_z[95:64]
    output logic [95:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int NST = 8;

    logic [31:0] near_reg;
    logic [31:0] far_reg;
    logic [15:0] cutoff_reg;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    logic [15:0]        dep0_reg;
    logic [31:0]        near0_reg;
    logic signed [32:0] diff0_reg;
    logic signed [31:0] tx0_reg, ty0_reg;
    logic signed [49:0] prod1_reg;
    logic [31:0]        near1_reg;
    logic signed [31:0] tx1_reg, ty1_reg;
    logic signed [33:0] z2_reg;
    logic signed [31:0] tx2_reg, ty2_reg;
    logic signed [65:0] px3_reg, py3_reg;
    logic signed [33:0] z3_reg;
    logic signed [35:0] cx4_reg, cy4_reg;
    logic signed [33:0] z4_reg;
    logic signed [ACC_W-1:0] tr5_reg [3];
    logic signed [ACC_W-1:0] tu5_reg [3];
    logic signed [ACC_W-1:0] tf5_reg [3];
    logic signed [ACC_W-1:0] sum6_reg [3];
    logic [95:0]        out_reg;

    logic [5:0]       col;
    logic [5:0]       row;
    logic [5:0]       col_idx;
    logic             pix_ok;
    logic             pose_start;
    logic             pose_idle;
    frame_t           frame;
    logic signed [ACC_W-1:0] z_rnd;
    logic signed [ACC_W-1:0] cx_rnd;
    logic signed [ACC_W-1:0] cy_rnd;
    logic [2:0][31:0] pos_in;
    logic [2:0][31:0] dir_in;
    logic [2:0][31:0] up_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg   <= NEAR_RESET;
            far_reg    <= FAR_RESET;
            cutoff_reg <= CUTOFF_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NEAR:   near_reg   <= cfg_data;
                REG_FAR:    far_reg    <= cfg_data;
                REG_CUTOFF: cutoff_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // a stage advances when it is empty or the next one advances
    always_comb begin
        rdy[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = pose_idle && rdy[0];

    assign col     = s_tdata[27:22];
    assign row     = s_tdata[21:16];
    assign col_idx = 6'(SPAN) - col;
    assign pix_ok  = s_tvalid && s_tready && s_tuser[0]
                     && (s_tdata[15:0] <= cutoff_reg)
                     && ({1'b0, col} < 7'(IMAGE_SIDE))
                     && ({1'b0, row} < 7'(IMAGE_SIDE));
    assign pose_start = s_tvalid && s_tready && !s_tuser[0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_in[i] = s_tdata[28 + 32*i +: 32];
            dir_in[i] = s_tdata[124 + 32*i +: 32];
            up_in[i]  = s_tdata[220 + 32*i +: 32];
        end
    end

    dimg_pose u_pose (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (pose_start),
        .pos        (pos_in),
        .dir        (dir_in),
        .upvec      (up_in),
        .pipe_empty (~|v_reg),
        .idle       (pose_idle),
        .frame      (frame)
    );

    assign z_rnd  = rnd16(ACC_W'(prod1_reg));
    assign cx_rnd = rnd16(ACC_W'(px3_reg));
    assign cy_rnd = rnd16(ACC_W'(py3_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= (k == 0) ? pix_ok : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            dep0_reg  <= s_tdata[15:0];
            near0_reg <= near_reg;
            diff0_reg <= $signed({1'b0, far_reg}) - $signed({1'b0, near_reg});
            tx0_reg   <= TAN_TAB[col_idx[IDX_W-1:0]];
            ty0_reg   <= TAN_TAB[row[IDX_W-1:0]];
        end
        if (rdy[1]) begin
            prod1_reg <= 50'($signed({1'b0, dep0_reg})) * 50'(diff0_reg);
            near1_reg <= near0_reg;
            tx1_reg   <= tx0_reg;
            ty1_reg   <= ty0_reg;
        end
        if (rdy[2]) begin
            z2_reg  <= $signed({2'b00, near1_reg}) + z_rnd[33:0];
            tx2_reg <= tx1_reg;
            ty2_reg <= ty1_reg;
        end
        if (rdy[3]) begin
            px3_reg <= tx2_reg * z2_reg;
            py3_reg <= ty2_reg * z2_reg;
            z3_reg  <= z2_reg;
        end
        if (rdy[4]) begin
            cx4_reg <= cx_rnd[35:0];
            cy4_reg <= cy_rnd[35:0];
            z4_reg  <= z3_reg;
        end
        if (rdy[5]) begin
            for (int i = 0; i < 3; i++) begin
                tr5_reg[i] <= ACC_W'($signed(frame.right[i])) * ACC_W'(cx4_reg);
                tu5_reg[i] <= ACC_W'($signed(frame.up[i])) * ACC_W'(cy4_reg);
                tf5_reg[i] <= ACC_W'($signed(frame.fwd[i])) * ACC_W'(z4_reg);
            end
        end
        if (rdy[6]) begin
            for (int i = 0; i < 3; i++) begin
                sum6_reg[i] <= (ACC_W'($signed(frame.origin[i])) <<< 16)
                               + tr5_reg[i] + tu5_reg[i] + tf5_reg[i];
            end
        end
        if (rdy[7]) begin
            for (int i = 0; i < 3; i++) begin
                out_reg[32*i +: 32] <= sat32(rnd16(sum6_reg[i]));
            end
        end
    end

    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = out_reg;

endmodule

>>> src/dimg_pose.sv
module dimg_pose
    import dimg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [2:0][31:0] pos,
    input  logic [2:0][31:0] dir,
    input  logic [2:0][31:0] upvec,
    input  logic             pipe_empty,
    output logic             idle,
    output frame_t           frame
);

    localparam logic [2:0] P_IDLE   = 3'd0;
    localparam logic [2:0] P_SHIFT  = 3'd1;
    localparam logic [2:0] P_SQ     = 3'd2;
    localparam logic [2:0] P_SQRT   = 3'd3;
    localparam logic [2:0] P_DIV    = 3'd4;
    localparam logic [2:0] P_NDONE  = 3'd5;
    localparam logic [2:0] P_XPROD  = 3'd6;
    localparam logic [2:0] P_COMMIT = 3'd7;

    logic [2:0]         state_reg;
    logic               phase_reg;
    logic [5:0]         cnt_reg;
    logic [1:0]         idx_reg;
    logic [48:0]        mag_reg [3];
    logic               neg_reg [3];
    logic [63:0]        sum_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        len_reg;
    logic [47:0]        num_reg;
    logic [31:0]        drem_reg;
    logic [16:0]        quo_reg;
    logic signed [31:0] res_reg [3];
    logic signed [31:0] xa_reg [3];
    logic signed [31:0] xb_reg [3];
    logic signed [49:0] acc_reg;
    logic [2:0][31:0]   org_new_reg;
    logic [2:0][31:0]   fwd_new_reg;
    logic [2:0][31:0]   right_new_reg;
    logic [2:0][31:0]   up_new_reg;
    frame_t             frame_reg;

    logic [1:0]         xi;
    logic [1:0]         ia;
    logic [1:0]         ib;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;
    logic signed [49:0] total;
    logic [48:0]        total_mag;
    logic [63:0]        trial;
    logic               sq_ge;
    logic [63:0]        root_next;
    logic [32:0]        dsh;
    logic               dge;
    logic [32:0]        dsub;
    logic [16:0]        q_fin;
    logic               shift_need;
    logic signed [ACC_W-1:0] up_rnd;

    always_comb begin
        xi = cnt_reg[2:1];
        case (xi)
            2'd0: begin ia = 2'd1; ib = 2'd2; end
            2'd1: begin ia = 2'd2; ib = 2'd0; end
            2'd2: begin ia = 2'd0; ib = 2'd1; end
            default: begin ia = 2'd0; ib = 2'd0; end
        endcase
        if (cnt_reg[0]) begin
            {ia, ib} = {ib, ia};
        end
        if (state_reg == P_SQ) begin
            mul_a = $signed({2'b00, mag_reg[idx_reg][30:0]});
            mul_b = $signed({2'b00, mag_reg[idx_reg][30:0]});
        end else begin
            mul_a = 33'(xa_reg[ia]);
            mul_b = 33'(xb_reg[ib]);
        end
    end

    assign prod      = mul_a * mul_b;
    assign total     = acc_reg - prod[49:0];
    assign total_mag = total[49] ? 49'(-total) : 49'(total);
    assign up_rnd    = rnd16(ACC_W'(total));

    assign trial     = root_reg + bit_reg;
    assign sq_ge     = rem_reg >= trial;
    assign root_next = sq_ge ? (root_reg >> 1) + bit_reg : root_reg >> 1;

    assign dsh   = {drem_reg, num_reg[47]};
    assign dge   = dsh >= {1'b0, len_reg};
    assign dsub  = dsh - {1'b0, len_reg};
    assign q_fin = {quo_reg[15:0], dge};

    assign shift_need = (|mag_reg[0][48:31]) | (|mag_reg[1][48:31]) | (|mag_reg[2][48:31]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            frame_reg <= '0;
        end else begin
            case (state_reg)
                P_IDLE: begin
                    if (start) begin
                        org_new_reg <= pos;
                        for (int i = 0; i < 3; i++) begin
                            neg_reg[i] <= dir[i][31];
                            mag_reg[i] <= dir[i][31] ? 49'(-$signed({1'b1, dir[i]}))
                                                     : 49'(dir[i]);
                            xa_reg[i]  <= $signed(upvec[i]);
                        end
                        phase_reg <= 1'b0;
                        state_reg <= P_SHIFT;
                    end
                end
                P_SHIFT: begin
                    if (shift_need) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end else begin
                        sum_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= P_SQ;
                    end
                end
                P_SQ: begin
                    sum_reg <= sum_reg + 64'(prod[61:0]);
                    if (idx_reg == 2'd2) begin
                        rem_reg   <= sum_reg + 64'(prod[61:0]);
                        root_reg  <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= '0;
                        state_reg <= P_SQRT;
                    end else begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                P_SQRT: begin
                    if (sq_ge) begin
                        rem_reg <= rem_reg - trial;
                    end
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) begin
                        len_reg  <= root_next[31:0];
                        idx_reg  <= '0;
                        cnt_reg  <= '0;
                        drem_reg <= '0;
                        num_reg  <= {1'b0, mag_reg[0][30:0], 16'd0} + 48'(root_next[31:1]);
                        if (root_next == 64'd0) begin
                            for (int i = 0; i < 3; i++) begin
                                res_reg[i] <= '0;
                            end
                            state_reg <= P_NDONE;
                        end else begin
                            state_reg <= P_DIV;
                        end
                    end
                end
                P_DIV: begin
                    num_reg  <= num_reg << 1;
                    drem_reg <= dge ? dsub[31:0] : dsh[31:0];
                    quo_reg  <= q_fin;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd47) begin
                        res_reg[idx_reg] <= neg_reg[idx_reg] ? -$signed(32'(q_fin))
                                                             : $signed(32'(q_fin));
                        cnt_reg  <= '0;
                        drem_reg <= '0;
                        if (idx_reg == 2'd2) begin
                            state_reg <= P_NDONE;
                        end else begin
                            idx_reg <= idx_reg + 2'd1;
                            num_reg <= {1'b0, mag_reg[idx_reg + 2'd1][30:0], 16'd0}
                                       + 48'(len_reg[31:1]);
                        end
                    end
                end
                P_NDONE: begin
                    cnt_reg <= '0;
                    for (int i = 0; i < 3; i++) begin
                        xb_reg[i] <= res_reg[i];
                        if (phase_reg) begin
                            right_new_reg[i] <= res_reg[i];
                            xa_reg[i]        <= $signed(fwd_new_reg[i]);
                        end else begin
                            fwd_new_reg[i] <= res_reg[i];
                        end
                    end
                    state_reg <= P_XPROD;
                end
                P_XPROD: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (!cnt_reg[0]) begin
                        acc_reg <= prod[49:0];
                    end else if (phase_reg) begin
                        up_new_reg[xi] <= up_rnd[31:0];
                    end else begin
                        mag_reg[xi] <= total_mag;
                        neg_reg[xi] <= total[49];
                    end
                    if (cnt_reg == 6'd5) begin
                        if (phase_reg) begin
                            state_reg <= P_COMMIT;
                        end else begin
                            phase_reg <= 1'b1;
                            state_reg <= P_SHIFT;
                        end
                    end
                end
                P_COMMIT: begin
                    // hold the new frame until pixels taken earlier have left
                    if (pipe_empty) begin
                        frame_reg.origin <= org_new_reg;
                        frame_reg.right  <= right_new_reg;
                        frame_reg.up     <= up_new_reg;
                        frame_reg.fwd    <= fwd_new_reg;
                        state_reg        <= P_IDLE;
                    end
                end
                default: begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign idle  = (state_reg == P_IDLE);
    assign frame = frame_reg;

endmodule

>>> bench/tb_depth_image_to_world_points.sv
`timescale 1ns / 1ps

module tb_depth_image_to_world_points;
    import dimg_pkg::*;

    typedef struct {
        logic               is_pixel;
        logic [15:0]        depth;
        logic [11:0]        pix;
        logic signed [31:0] pos [3];
        logic signed [31:0] dir [3];
        logic signed [31:0] upv [3];
    } item_t;

    typedef struct {
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wz;
    } point_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [319:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [95:0]  m_tdata;
    logic         cfg_wr_en = 0;
    logic [1:0]   cfg_index = REG_NEAR;
    logic [31:0]  cfg_data = '0;

    depth_image_to_world_points uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // predictor state
    logic [31:0]        near_q, far_q;
    logic [15:0]        cutoff_q;
    logic signed [31:0] org [3], rgt [3], upa [3], fwd [3];
    longint             tangent [IMAGE_SIDE];

    item_t  pending_items [$];
    point_t expected_points [$];
    int     mismatches = 0;
    int     errors = 0;
    longint cycles = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    logic   hold_sender = 0;
    logic   done_feeding = 0;

    function automatic longint round_q16(longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + 32768) >>> 16;
        return v < 0 ? -m : m;
    endfunction

    function automatic logic [63:0] q30mul(logic [63:0] a, logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    task automatic make_tangents();
        logic [63:0] km, a, a2, t, s, c, q;
        longint k;
        for (int i = 0; i < IMAGE_SIDE; i++) begin
            k = 2 * i - (IMAGE_SIDE - 1);
            km = k < 0 ? -k : k;
            a = 64'd562209904 * km / (IMAGE_SIDE - 1);
            a2 = q30mul(a, a);
            t = 64'd1073741824 - a2 / 72;
            t = 64'd1073741824 - q30mul(a2, t) / 42;
            t = 64'd1073741824 - q30mul(a2, t) / 20;
            t = 64'd1073741824 - q30mul(a2, t) / 6;
            s = q30mul(a, t);
            c = 64'd1073741824 - a2 / 56;
            c = 64'd1073741824 - q30mul(a2, c) / 30;
            c = 64'd1073741824 - q30mul(a2, c) / 12;
            c = 64'd1073741824 - q30mul(a2, c) / 2;
            q = ((s << 16) + c / 2) / c;
            tangent[i] = k < 0 ? -longint'(q) : longint'(q);
        end
    endtask

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic unit_vector(input longint v [3], output logic signed [31:0] o [3]);
        logic [63:0] m [3];
        logic [63:0] mx, sum, len, u;
        int sh;
        mx = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        while ((mx >> sh) >= 64'h8000_0000) sh++;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= sh;
            sum += m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                o[i] = 0;
            end else begin
                u = (m[i] * 65536 + len / 2) / len;
                o[i] = v[i] < 0 ? -u[31:0] : u[31:0];
            end
        end
    endtask

    task automatic predict_item(input item_t it);
        longint d [3], u [3], c [3];
        longint diff, z, cx, cy, s;
        int col, row;
        logic [31:0] w [3];
        point_t p;
        if (!it.is_pixel) begin
            for (int i = 0; i < 3; i++) begin
                org[i] = it.pos[i];
                d[i] = it.dir[i];
                u[i] = it.upv[i];
            end
            unit_vector(d, fwd);
            c[0] = u[1] * fwd[2] - u[2] * fwd[1];
            c[1] = u[2] * fwd[0] - u[0] * fwd[2];
            c[2] = u[0] * fwd[1] - u[1] * fwd[0];
            unit_vector(c, rgt);
            upa[0] = round_q16(longint'(fwd[1]) * rgt[2] - longint'(fwd[2]) * rgt[1]);
            upa[1] = round_q16(longint'(fwd[2]) * rgt[0] - longint'(fwd[0]) * rgt[2]);
            upa[2] = round_q16(longint'(fwd[0]) * rgt[1] - longint'(fwd[1]) * rgt[0]);
            return;
        end
        if (it.depth > cutoff_q) return;
        col = it.pix[11:6];
        row = it.pix[5:0];
        diff = longint'(far_q) - longint'(near_q);
        z = longint'(near_q) + round_q16(longint'(it.depth) * diff);
        cx = round_q16(tangent[IMAGE_SIDE - 1 - col] * z);
        cy = round_q16(tangent[row] * z);
        for (int i = 0; i < 3; i++) begin
            s = longint'(org[i]) * 65536 + longint'(rgt[i]) * cx
              + longint'(upa[i]) * cy + longint'(fwd[i]) * z;
            s = round_q16(s);
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            w[i] = s[31:0];
        end
        p.wx = w[0];
        p.wy = w[1];
        p.wz = w[2];
        expected_points.push_back(p);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [319:0] pack_item(item_t it);
        logic [319:0] v;
        v = '0;
        v[15:0] = it.depth;
        v[27:16] = it.pix;
        for (int i = 0; i < 3; i++) begin
            v[28 + 32 * i +: 32] = it.pos[i];
            v[124 + 32 * i +: 32] = it.dir[i];
            v[220 + 32 * i +: 32] = it.upv[i];
        end
        return v;
    endfunction

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (s_tvalid && s_tready) begin
            predict_item(pending_items.pop_front());
        end
        if (!s_tvalid || s_tready) begin
            if (send_gap > 0 || hold_sender || pending_items.size() == 0) begin
                s_tvalid <= 0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                // the transferred item is already popped, so the head is next
                item_t nx;
                nx = pending_items[0];
                if ($urandom_range(0, 5) == 0) begin
                    s_tvalid <= 0;
                    send_gap <= random_gap();
                end else begin
                    s_tvalid <= 1;
                    s_tdata <= pack_item(nx);
                    s_tuser <= nx.is_pixel;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            point_t e;
            if (expected_points.size() == 0) begin
                errors <= errors + 1;
                if (mismatches < 10) $display("unexpected result %h", m_tdata);
                mismatches <= mismatches + 1;
            end else begin
                e = expected_points.pop_front();
                if (m_tdata !== {e.wz, e.wy, e.wx}) begin
                    errors <= errors + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected x %h y %h z %h, got x %h y %h z %h",
                                 e.wx, e.wy, e.wz, m_tdata[31:0], m_tdata[63:32],
                                 m_tdata[95:64]);
                    mismatches <= mismatches + 1;
                end
            end
        end
        if (recv_gap > 0) begin
            m_tready <= 0;
            recv_gap <= recv_gap - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 0;
            recv_gap <= random_gap();
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (cycles > 3000000) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic item_t pose_item(int mode);
        item_t it;
        it.is_pixel = 0;
        it.depth = $urandom;
        it.pix = $urandom;
        for (int i = 0; i < 3; i++) begin
            it.pos[i] = $urandom;
            it.dir[i] = $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
            it.upv[i] = $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
        end
        if (mode == 1) begin
            it.dir = '{0, 0, 0};
        end else if (mode == 2) begin
            it.upv = it.dir;
        end else if (mode == 3) begin
            for (int i = 0; i < 3; i++) begin
                it.dir[i] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                it.upv[i] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                it.pos[i] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            end
        end else if (mode == 4) begin
            for (int i = 0; i < 3; i++) begin
                it.dir[i] = $urandom;
                it.upv[i] = $urandom;
            end
        end
        return it;
    endfunction

    function automatic item_t pixel_item(logic [15:0] dep, logic [11:0] pix);
        item_t it;
        it.is_pixel = 1;
        it.depth = dep;
        it.pix = pix;
        for (int i = 0; i < 3; i++) begin
            it.pos[i] = $urandom;
            it.dir[i] = $urandom;
            it.upv[i] = $urandom;
        end
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_points.size() != 0) @(posedge aclk);
        // a pose item may still be in the look-at unit
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            REG_NEAR:   near_q = val;
            REG_FAR:    far_q = val;
            REG_CUTOFF: cutoff_q = val[15:0];
            default: ;
        endcase
    endtask

    initial begin
        logic [31:0] settings [5][3];
        near_q = NEAR_RESET;
        far_q = FAR_RESET;
        cutoff_q = CUTOFF_RESET;
        for (int i = 0; i < 3; i++) begin
            org[i] = 0;
            rgt[i] = 0;
            upa[i] = 0;
            fwd[i] = 0;
        end
        make_tangents();
        settings = '{'{32'd0, 32'hffffffff, 32'hffff},
                     '{32'hffffffff, 32'd0, 32'd0},
                     '{32'd65536, 32'd327680, 32'd40000},
                     '{32'd6554, 32'd655360, 32'd58982},
                     '{32'd131072, 32'd65536, 32'd65535}};
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // directed: a pixel on the zero frame, then poses and edge pixels
        pending_items.push_back(pixel_item(16'd0, 12'd0));
        pending_items.push_back(pose_item(0));
        pending_items.push_back(pixel_item(16'd0, 12'd0));
        pending_items.push_back(pixel_item(16'd58982, 12'hfff));
        pending_items.push_back(pixel_item(16'd58983, 12'h820));
        pending_items.push_back(pixel_item(16'hffff, 12'h000));
        pending_items.push_back(pixel_item(16'd1000, 12'h03f));
        pending_items.push_back(pixel_item(16'd30000, 12'hfc0));
        pending_items.push_back(pose_item(1));
        pending_items.push_back(pixel_item(16'd20000, 12'h555));
        pending_items.push_back(pose_item(2));
        pending_items.push_back(pixel_item(16'd20000, 12'haaa));
        pending_items.push_back(pose_item(3));
        pending_items.push_back(pixel_item(16'd50000, 12'hfff));
        pending_items.push_back(pixel_item(16'd0, 12'h000));
        pending_items.push_back(pose_item(4));
        pending_items.push_back(pixel_item(16'd100, 12'h7df));
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_NEAR, settings[ph][0]);
            write_reg(REG_FAR, settings[ph][1]);
            write_reg(REG_CUTOFF, settings[ph][2]);
            pending_items.push_back(pose_item($urandom_range(0, 4)));
            for (int n = 0; n < 206; n++) begin
                if ($urandom_range(0, 49) == 0)
                    pending_items.push_back(pose_item($urandom_range(0, 4)));
                else if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(pixel_item($urandom, $urandom));
                else
                    pending_items.push_back(pixel_item(
                        $urandom_range(0, settings[ph][2][15:0]), $urandom));
            end
            if (ph == 2) begin
                // hold the sender until all results are in
                while (pending_items.size() > 100) @(posedge aclk);
                hold_sender <= 1;
                @(posedge aclk);
                while (s_tvalid) @(posedge aclk);
                while (expected_points.size() != 0) @(posedge aclk);
                repeat (20) @(posedge aclk);
                hold_sender <= 0;
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
